### rtl/core/rtm2q_pkg.sv
// rtm2q_pkg: words, lane layout and the square root digit step
// shared by the stages, the top level and the bench of the rotation matrix to quaternion unit
// no dependencies
`timescale 1ns / 1ps

package rtm2q_pkg;

    // fixed point format of the matrix entries and quaternion parts
    localparam int Q_FRAC = 14;
    localparam int Q_ONE  = 16384;

    // one plus three entries, as a signed sum
    localparam int SUM_W   = 19;
    // clamped (non-negative) sum
    localparam int CLAMP_W = 17;
    // radicand: clamped sum shifted up by the fraction bits
    localparam int RAD_W   = 32;
    // integer root of the radicand
    localparam int ROOT_W  = RAD_W / 2;
    // partial remainder
    localparam int REM_W   = ROOT_W + 3;

    // root digits per pipeline stage, must divide ROOT_W
    localparam int STEPS_PER_STAGE = 2;

    // lane order inside the root pipeline
    localparam int LANES  = 4;
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    // input word: nine rotation entries
    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } mat_t;

    // output word: quaternion
    typedef struct packed {
        logic        [14:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } quat_t;

    // one lane of the digit-by-digit square root
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } lane_t;

    // word carried through the root pipeline
    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic  [LANES-1:0] neg;
    } root_word_t;

    // one root digit: bring down two radicand bits, try the next root bit
    function automatic lane_t root_step(lane_t l);
        lane_t            o;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {l.rem[REM_W-3:0], l.rad[RAD_W-1 -: 2]};
        trial  = REM_W'({l.root, 2'b01});
        o.rad  = {l.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            o.rem  = rem_sh - trial;
            o.root = {l.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = rem_sh;
            o.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### rtl/core/rtm2q_stream_if.sv
// rtm2q_stream_if: valid/ready channel carrying one word of a given type
// used for the ports and for the links between pipeline stages
// no dependencies
`timescale 1ns / 1ps

interface rtm2q_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/core/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion unit. Takes one word of nine Q2.14 rotation
// entries per cycle and returns one Q2.14 quaternion word for each, in order.
// Each part's magnitude is floor(sqrt(max(0, s) * 2^14)) / 2 with s one plus
// the diagonal entries under that part's sign pattern; x, y and z are negated
// when their off-diagonal difference is below zero, w is never negative and
// nothing is renormalized. One stage forms the sums, the 16 root digits are
// spread over the square root stages, STEPS_PER_STAGE digits each, and one
// stage applies the signs. Throughput is one word per cycle; a stall on the
// output holds the pipeline and bubbles are squeezed out.
// depends on rtm2q_pkg, rtm2q_stream_if, rtm2q_prep, rtm2q_root_stage, rtm2q_out
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit #(
    parameter int STEPS_PER_STAGE = rtm2q_pkg::STEPS_PER_STAGE
) (
    input  logic          clk,
    input  logic          rst_n,
    rtm2q_stream_if.sink   mat,
    rtm2q_stream_if.source quat
);

    localparam int N_STAGES = rtm2q_pkg::ROOT_W / STEPS_PER_STAGE;

    // links between stages: link[0] leaves the sum stage
    rtm2q_stream_if #(.payload_t(rtm2q_pkg::root_word_t)) link [N_STAGES+1] ();

    // sums, clamp and signs
    rtm2q_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (mat),
        .down  (link[0])
    );

    // square root pipeline
    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_root
        rtm2q_root_stage #(
            .STEPS_PER_STAGE (STEPS_PER_STAGE)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (link[i]),
            .down  (link[i+1])
        );
    end

    // signs and output register
    rtm2q_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (link[N_STAGES]),
        .down  (quat)
    );

endmodule

### rtl/core/rtm2q_prep.sv
// rtm2q_prep: first pipeline stage, diagonal sums, clamp and part signs
// depends on rtm2q_pkg and rtm2q_stream_if
`timescale 1ns / 1ps

module rtm2q_prep (
    input  logic          clk,
    input  logic          rst_n,
    rtm2q_stream_if.sink   up,
    rtm2q_stream_if.source down
);

    logic                       valid_reg;
    rtm2q_pkg::root_word_t      data_reg;
    rtm2q_pkg::root_word_t      data_next;
    rtm2q_pkg::mat_t            m;

    logic signed [rtm2q_pkg::SUM_W-1:0] one_s;
    logic signed [rtm2q_pkg::SUM_W-1:0] d00;
    logic signed [rtm2q_pkg::SUM_W-1:0] d11;
    logic signed [rtm2q_pkg::SUM_W-1:0] d22;
    logic signed [rtm2q_pkg::SUM_W-1:0] sum [rtm2q_pkg::LANES];
    logic signed [16:0]                 diff_x;
    logic signed [16:0]                 diff_y;
    logic signed [16:0]                 diff_z;

    assign m = up.data;

    // sums with per-part signs on the diagonal
    assign one_s = rtm2q_pkg::SUM_W'(rtm2q_pkg::Q_ONE);
    assign d00   = rtm2q_pkg::SUM_W'(m.r00);
    assign d11   = rtm2q_pkg::SUM_W'(m.r11);
    assign d22   = rtm2q_pkg::SUM_W'(m.r22);

    assign sum[rtm2q_pkg::LANE_W] = one_s + d00 + d11 + d22;
    assign sum[rtm2q_pkg::LANE_X] = one_s + d00 - d11 - d22;
    assign sum[rtm2q_pkg::LANE_Y] = one_s - d00 + d11 - d22;
    assign sum[rtm2q_pkg::LANE_Z] = one_s - d00 - d11 + d22;

    // off-diagonal differences give the signs of x, y, z
    assign diff_x = 17'(m.r21) - 17'(m.r12);
    assign diff_y = 17'(m.r02) - 17'(m.r20);
    assign diff_z = 17'(m.r10) - 17'(m.r01);

    // clamp at zero and form the radicands
    always_comb
    begin
        for (int l = 0; l < rtm2q_pkg::LANES; l++)
        begin
            data_next.lane[l].rem  = '0;
            data_next.lane[l].root = '0;
            if (sum[l][rtm2q_pkg::SUM_W-1])
                data_next.lane[l].rad = '0;
            else
                data_next.lane[l].rad = rtm2q_pkg::RAD_W'(
                    {sum[l][rtm2q_pkg::CLAMP_W-1:0], rtm2q_pkg::Q_FRAC'(0)});
        end
        data_next.neg                    = '0;
        data_next.neg[rtm2q_pkg::LANE_X] = diff_x[16];
        data_next.neg[rtm2q_pkg::LANE_Y] = diff_y[16];
        data_next.neg[rtm2q_pkg::LANE_Z] = diff_z[16];
    end

    // stage register, moves when the next stage has room
    assign up.ready = !valid_reg || down.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up.ready)
            valid_reg <= up.valid;
    end

    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
            data_reg <= data_next;
    end

    assign down.valid = valid_reg;
    assign down.data  = data_reg;

endmodule

### rtl/core/rtm2q_root_stage.sv
// rtm2q_root_stage: one stage of the square root pipeline,
// STEPS_PER_STAGE digits for all four lanes
// depends on rtm2q_pkg and rtm2q_stream_if
`timescale 1ns / 1ps

module rtm2q_root_stage #(
    parameter int STEPS_PER_STAGE = rtm2q_pkg::STEPS_PER_STAGE
) (
    input  logic          clk,
    input  logic          rst_n,
    rtm2q_stream_if.sink   up,
    rtm2q_stream_if.source down
);

    logic                  valid_reg;
    rtm2q_pkg::root_word_t data_reg;
    rtm2q_pkg::root_word_t data_next;

    // root digits for this stage, signs pass through
    always_comb
    begin
        data_next = up.data;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            for (int l = 0; l < rtm2q_pkg::LANES; l++)
                data_next.lane[l] = rtm2q_pkg::root_step(data_next.lane[l]);
        end
    end

    // stage register
    assign up.ready = !valid_reg || down.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up.ready)
            valid_reg <= up.valid;
    end

    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
            data_reg <= data_next;
    end

    assign down.valid = valid_reg;
    assign down.data  = data_reg;

endmodule

### rtl/core/rtm2q_out.sv
// rtm2q_out: last pipeline stage, halves the roots, applies signs and
// holds the quaternion word for the output channel
// depends on rtm2q_pkg and rtm2q_stream_if
`timescale 1ns / 1ps

module rtm2q_out (
    input  logic          clk,
    input  logic          rst_n,
    rtm2q_stream_if.sink   up,
    rtm2q_stream_if.source down
);

    logic                           valid_reg;
    rtm2q_pkg::quat_t               data_reg;
    rtm2q_pkg::quat_t               data_next;
    rtm2q_pkg::root_word_t          w;
    logic [15:0]                    mag [rtm2q_pkg::LANES];
    logic [15:0]                    part [rtm2q_pkg::LANES];

    assign w = up.data;

    // magnitude is the root shifted right by one, negate where flagged
    always_comb
    begin
        for (int l = 0; l < rtm2q_pkg::LANES; l++)
        begin
            mag[l] = 16'(w.lane[l].root[rtm2q_pkg::ROOT_W-1:1]);
            if (w.neg[l])
                part[l] = 16'd0 - mag[l];
            else
                part[l] = mag[l];
        end
        data_next.qw = mag[rtm2q_pkg::LANE_W][14:0];
        data_next.qx = part[rtm2q_pkg::LANE_X];
        data_next.qy = part[rtm2q_pkg::LANE_Y];
        data_next.qz = part[rtm2q_pkg::LANE_Z];
    end

    // output register
    assign up.ready = !valid_reg || down.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up.ready)
            valid_reg <= up.valid;
    end

    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
            data_reg <= data_next;
    end

    assign down.valid = valid_reg;
    assign down.data  = data_reg;

endmodule

### dv/tb_rotation_matrix_to_quaternion_unit.sv
// tb_rotation_matrix_to_quaternion_unit: self-checking bench for the rotation matrix
// to quaternion unit, directed rows then random matrices under random stalls
// depends on rtm2q_pkg, rtm2q_stream_if and rotation_matrix_to_quaternion_unit
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_unit;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int PIPE_LATENCY   = 10;
    localparam int RANDOM_WORDS   = 1200;
    localparam int MAX_GAP        = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT        = 300;
    localparam int DRAIN_AT       = 700;
    localparam int BURST_WORDS    = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIR_ROWS       = 22;

    // traffic modes for either side
    localparam int MODE_STEADY = 0;
    localparam int MODE_RANDOM = 1;
    localparam int MODE_BURSTY = 2;

    // handy Q2.14 values
    localparam int ONE  = 16384;
    localparam int PMAX = 32767;
    localparam int NMIN = -32768;

    // one directed row: matrix, and a typed quaternion where it is obvious
    typedef struct {
        rtm2q_pkg::mat_t  m;
        bit               typed;
        rtm2q_pkg::quat_t q;
    } dir_row_t;

    logic clk;
    logic rst_n;

    rtm2q_stream_if #(.payload_t(rtm2q_pkg::mat_t))  mat_if ();
    rtm2q_stream_if #(.payload_t(rtm2q_pkg::quat_t)) quat_if ();

    rotation_matrix_to_quaternion_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat_if),
        .quat  (quat_if)
    );

    rtm2q_pkg::quat_t quat_expected [$];
    dir_row_t dir_table [DIR_ROWS];

    int sent_words;
    int checked_words;
    int mismatches;
    int orphan_words;
    int neg_parts;
    int zero_parts;
    int stall_cycles;
    int holds_done;
    int send_mode;
    int burst_left;
    bit hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // build a matrix from nine integer entries
    function automatic rtm2q_pkg::mat_t entries(int a00, int a01, int a02,
                                                int a10, int a11, int a12,
                                                int a20, int a21, int a22);
        rtm2q_pkg::mat_t m;
        m.r00 = 16'(a00);
        m.r01 = 16'(a01);
        m.r02 = 16'(a02);
        m.r10 = 16'(a10);
        m.r11 = 16'(a11);
        m.r12 = 16'(a12);
        m.r20 = 16'(a20);
        m.r21 = 16'(a21);
        m.r22 = 16'(a22);
        return m;
    endfunction

    function automatic rtm2q_pkg::quat_t quat(int w, int x, int y, int z);
        rtm2q_pkg::quat_t q;
        q.qw = 15'(w);
        q.qx = 16'(x);
        q.qy = 16'(y);
        q.qz = 16'(z);
        return q;
    endfunction

    // floor(sqrt(sum << 14)) / 2, zero for a negative sum
    function automatic int part_magnitude(int sum);
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        if (sum <= 0)
            return 0;
        radicand = longint'(sum) << rtm2q_pkg::Q_FRAC;
        root     = 0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return int'(root >> 1);
    endfunction

    // magnitude with the sign of the off-diagonal difference
    function automatic logic signed [15:0] signed_part(int sum, int diff);
        int mag;
        mag = part_magnitude(sum);
        return (diff < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    // quaternion the unit should return for one matrix
    function automatic rtm2q_pkg::quat_t quat_of_matrix(rtm2q_pkg::mat_t m);
        int               a00;
        int               a11;
        int               a22;
        rtm2q_pkg::quat_t q;
        a00  = m.r00;
        a11  = m.r11;
        a22  = m.r22;
        q.qw = 15'(part_magnitude(rtm2q_pkg::Q_ONE + a00 + a11 + a22));
        q.qx = signed_part(rtm2q_pkg::Q_ONE + a00 - a11 - a22,
                           int'(m.r21) - int'(m.r12));
        q.qy = signed_part(rtm2q_pkg::Q_ONE - a00 + a11 - a22,
                           int'(m.r02) - int'(m.r20));
        q.qz = signed_part(rtm2q_pkg::Q_ONE - a00 - a11 + a22,
                           int'(m.r10) - int'(m.r01));
        return q;
    endfunction

    // random matrix: raw bits, rotation-like, near-symmetric or extreme entries
    function automatic rtm2q_pkg::mat_t random_matrix();
        rtm2q_pkg::mat_t m;
        int              pick;
        int              specials [7] = '{NMIN, PMAX, 0, -1, 1, ONE, -ONE};
        pick = $urandom_range(0, 99);
        for (int k = 0; k < 9; k++)
        begin
            if (pick < 25)
                m[16*k +: 16] = 16'($urandom);
            else if (pick < 90)
                m[16*k +: 16] = 16'(int'($urandom_range(0, 2 * ONE)) - ONE);
            else
                m[16*k +: 16] = 16'(specials[$urandom_range(0, 6)]);
        end
        // off-diagonal pairs equal or one apart, so the signs sit on the edge
        if (pick >= 75 && pick < 90)
        begin
            m.r21 = 16'(int'(m.r12) + int'($urandom_range(0, 2)) - 1);
            m.r02 = 16'(int'(m.r20) + int'($urandom_range(0, 2)) - 1);
            m.r10 = 16'(int'(m.r01) + int'($urandom_range(0, 2)) - 1);
        end
        return m;
    endfunction

    // gap before the next input word, per sender mode
    function automatic int sender_gap();
        case (send_mode)
            MODE_STEADY: return 0;
            MODE_RANDOM: return $urandom_range(0, MAX_GAP);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
        endcase
    endfunction

    // offer one matrix and hold it until the unit takes it
    task automatic offer_matrix(input rtm2q_pkg::mat_t m, input bit typed,
                                input rtm2q_pkg::quat_t q);
        int gap;
        if (sent_words % 40 == 0)
            send_mode = $urandom_range(MODE_STEADY, MODE_BURSTY);
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
            gap = sender_gap();
        if (gap > 0)
        begin
            mat_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mat_if.valid <= 1'b1;
        mat_if.data  <= m;
        do
            @(posedge clk);
        while (!mat_if.ready);
        quat_expected.push_back(typed ? q : quat_of_matrix(m));
        sent_words++;
    endtask

    // stop offering until every quaternion in flight is back
    task automatic drain_pipeline();
        mat_if.valid <= 1'b0;
        while (quat_expected.size() != 0)
            @(posedge clk);
    endtask

    // output side: random ready, with one long hold-off on request
    initial
    begin
        int w;
        int sink_mode;
        int words_seen;
        quat_if.ready <= 1'b0;
        sink_mode  = MODE_STEADY;
        words_seen = 0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (words_seen % 32 == 0)
                sink_mode = $urandom_range(MODE_STEADY, MODE_BURSTY);
            if (hold_req)
            begin
                hold_req = 1'b0;
                w = HOLD_CYCLES;
                holds_done++;
            end
            else if (sink_mode == MODE_STEADY)
                w = 0;
            else if (sink_mode == MODE_RANDOM)
                w = $urandom_range(0, MAX_GAP);
            else
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            if (w > 0)
            begin
                quat_if.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            quat_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!quat_if.valid);
            words_seen++;
        end
    end

    // compare each returned quaternion with the oldest expected one
    initial
    begin
        rtm2q_pkg::quat_t got;
        rtm2q_pkg::quat_t want;
        bit               bad;
        forever
        begin
            @(posedge clk);
            if (mat_if.valid === 1'b1 && mat_if.ready !== 1'b1)
                stall_cycles++;
            if (quat_if.valid === 1'b1 && quat_if.ready === 1'b1)
            begin
                got = quat_if.data;
                if (quat_expected.size() == 0)
                begin
                    orphan_words++;
                    if (mismatches + orphan_words <= REPORT_LIMIT)
                        $display({"%0t: quaternion word with nothing expected: ",
                                  "w=%0d x=%0d y=%0d z=%0d"},
                                 $realtime, got.qw, got.qx, got.qy, got.qz);
                end
                else
                begin
                    want = quat_expected.pop_front();
                    checked_words++;
                    bad = (got.qw !== want.qw) || (got.qx !== want.qx) ||
                          (got.qy !== want.qy) || (got.qz !== want.qz);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches + orphan_words <= REPORT_LIMIT)
                            $display({"%0t: word %0d: expected w=%0d x=%0d y=%0d z=%0d, ",
                                      "got w=%0d x=%0d y=%0d z=%0d"},
                                     $realtime, checked_words - 1,
                                     want.qw, want.qx, want.qy, want.qz,
                                     got.qw, got.qx, got.qy, got.qz);
                    end
                    neg_parts  += (want.qx < 0) + (want.qy < 0) + (want.qz < 0);
                    zero_parts += (want.qw == 0) + (want.qx == 0) +
                                  (want.qy == 0) + (want.qz == 0);
                end
            end
        end
    end

    // watchdog: too long without any word moving ends the run
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((mat_if.valid === 1'b1 && mat_if.ready === 1'b1) ||
                (quat_if.valid === 1'b1 && quat_if.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d quaternions outstanding",
                 WATCHDOG_LIMIT, quat_expected.size());
        $display("rotation_matrix_to_quaternion_unit regression: fail");
        $finish;
    end

    // reset, directed rows, random matrices, end of run
    initial
    begin
        int leftover;
        rst_n        <= 1'b0;
        mat_if.valid <= 1'b0;
        mat_if.data  <= '0;
        sent_words    = 0;
        checked_words = 0;
        mismatches    = 0;
        orphan_words  = 0;
        neg_parts     = 0;
        zero_parts    = 0;
        stall_cycles  = 0;
        holds_done    = 0;
        send_mode     = MODE_STEADY;
        burst_left    = 0;
        hold_req      = 1'b0;

        // directed rows: zero matrix, identity, half turns, sign edges, extremes
        dir_table[0]  = '{entries(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                          quat(8192, 8192, 8192, 8192)};
        dir_table[1]  = '{entries(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1,
                          quat(ONE, 0, 0, 0)};
        dir_table[2]  = '{entries(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1'b1,
                          quat(0, ONE, 0, 0)};
        dir_table[3]  = '{entries(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 1'b1,
                          quat(0, 0, ONE, 0)};
        dir_table[4]  = '{entries(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE), 1'b1,
                          quat(0, 0, 0, ONE)};
        dir_table[5]  = '{entries(0, 0, 0, 0, 0, 1, 0, 0, 0), 1'b1,
                          quat(8192, -8192, 8192, 8192)};
        dir_table[6]  = '{entries(0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b1,
                          quat(8192, 8192, -8192, 8192)};
        dir_table[7]  = '{entries(0, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                          quat(8192, 8192, 8192, -8192)};
        dir_table[8]  = '{entries(0, 0, 0, 0, 0, PMAX, 0, NMIN, 0), 1'b1,
                          quat(8192, -8192, 8192, 8192)};
        dir_table[9]  = '{entries(0, 0, NMIN, 0, 0, 0, PMAX, 0, 0), 1'b1,
                          quat(8192, 8192, -8192, 8192)};
        dir_table[10] = '{entries(0, PMAX, 0, NMIN, 0, 0, 0, 0, 0), 1'b1,
                          quat(8192, 8192, 8192, -8192)};
        dir_table[11] = '{entries(0, NMIN, PMAX, PMAX, 0, NMIN, NMIN, PMAX, 0), 1'b1,
                          quat(8192, 8192, 8192, 8192)};
        dir_table[12] = '{entries(0, 5, 7, 5, 0, 9, 7, 9, 0), 1'b1,
                          quat(8192, 8192, 8192, 8192)};
        dir_table[13] = '{entries(PMAX, 0, 0, 0, PMAX, 0, 0, 0, PMAX), 1'b0, '0};
        dir_table[14] = '{entries(NMIN, 0, 0, 0, NMIN, 0, 0, 0, NMIN), 1'b0, '0};
        dir_table[15] = '{entries(PMAX, 0, 0, 0, NMIN, PMAX, 0, NMIN, NMIN), 1'b0, '0};
        dir_table[16] = '{entries(NMIN, NMIN, PMAX, 0, PMAX, 0, NMIN, 0, NMIN), 1'b0, '0};
        dir_table[17] = '{entries(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0};
        dir_table[18] = '{entries(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX),
                          1'b0, '0};
        dir_table[19] = '{entries(NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN),
                          1'b0, '0};
        dir_table[20] = '{entries(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE), 1'b0, '0};
        dir_table[21] = '{entries(-ONE - 1, 16'h5555, 16'hAAAA, 16'hAAAA, 0, 16'h5555,
                                  16'h5555, 16'hAAAA, 0), 1'b0, '0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            offer_matrix(dir_table[i].m, dir_table[i].typed, dir_table[i].q);
        drain_pipeline();

        // random matrices, with one long output hold-off and one full drain
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == HOLD_AT)
            begin
                hold_req   = 1'b1;
                burst_left = BURST_WORDS;
            end
            if (i == DRAIN_AT)
                drain_pipeline();
            offer_matrix(random_matrix(), 1'b0, '0);
        end
        mat_if.valid <= 1'b0;

        while (quat_expected.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        leftover = quat_expected.size();

        $display({"sent %0d matrices (%0d directed), checked %0d quaternions: ",
                  "%0d negative and %0d zero parts"},
                 sent_words, DIR_ROWS, checked_words, neg_parts, zero_parts);
        $display({"input stalled for %0d cycles, %0d long output hold-off(s); ",
                  "%0d mismatches, %0d unexpected"},
                 stall_cycles, holds_done, mismatches, orphan_words);
        if (mismatches == 0 && orphan_words == 0 && leftover == 0)
            $display("rotation_matrix_to_quaternion_unit regression: pass");
        else
            $display("rotation_matrix_to_quaternion_unit regression: fail");
        $finish;
    end

endmodule
